// ===== rtl/ita_pkg.sv =====
// shared types, codes and character constants for the integer to ascii formatter
package ita_pkg;

    localparam int DIGIT_BUFFER_DEPTH_DEF = 20;
    localparam int DEC_BITS               = 32;
    localparam int PTR_BITS               = 64;
    localparam int PREFIX_BITS            = 40;
    localparam int CONV_CNT_BITS          = 6;

    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_X        = 8'h78;
    localparam logic [7:0] CH_MINUS    = 8'h2d;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [PREFIX_BITS-1:0] NIL_TEXT = 40'h28_6e_69_6c_29;

    typedef enum logic [2:0] {
        OP_CHAR    = 3'd0,
        OP_SDEC    = 3'd1,
        OP_UDEC    = 3'd2,
        OP_PTR     = 3'd3,
        OP_HEXLO   = 3'd4,
        OP_HEXUP   = 3'd5,
        OP_PERCENT = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    typedef struct packed {
        logic [2:0]          opcode;
        logic [PTR_BITS-1:0] value;
    } in_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last_char;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_CONVERT,
        ST_SKIP,
        ST_DIGITS
    } state_t;

    typedef enum logic [2:0] {
        DU_HOLD,
        DU_LOAD_HEX,
        DU_LOAD_DEC,
        DU_DABBLE,
        DU_NIB
    } du_cmd_t;

    typedef struct packed {
        du_cmd_t             cmd;
        logic [PTR_BITS-1:0] operand;
    } du_ctl_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] d8;
        d8 = {4'b0000, d};
        if (d < 4'd10)
        begin
            return CH_ZERO + d8;
        end
        return (upper ? CH_UPPER_A : CH_LOWER_A) + d8 - 8'd10;
    endfunction

endpackage

// ===== rtl/integer_to_ascii_formatter_top.sv =====
// top level of the integer to ascii formatter
//
// input channel: in_valid / in_stall with in_data {opcode, value}, one
// conversion request per transfer. output channel: out_valid / out_stall with
// out_data {ascii_char, last_char}, one character per transfer, most
// significant digit first, last_char set on the final character.
// in_stall stays high from the cycle after a request is taken until its last
// character has been loaded into the output register; no-conversion requests
// produce no characters and leave the block idle.
// per request: decimal takes 32 double dabble steps on the digit register,
// hex and pointer skip them; then come the leading zero skip steps, the exit
// from the skip and the digits. the minus sign, the 0x prefix, char, percent
// and nil text go out one character per cycle while out_stall is low, and so
// do the digits. the digit register shift unit and the single output register
// set this pace.
// a prefix or single character moves from the prefix register to the output
// register once that can take it. reset clears the sequencer to idle and
// empties the output register. while out_stall is high the held character
// stays on out_data and the sequencer waits before producing the next one.
module integer_to_ascii_formatter_top #(
    parameter int DIGIT_BUFFER_DEPTH = ita_pkg::DIGIT_BUFFER_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ita_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output ita_pkg::out_t out_data
);
    import ita_pkg::*;

    du_ctl_t    du_ctl;
    logic [3:0] top_digit;

    ita_seq #(
        .DIGIT_BUFFER_DEPTH(DIGIT_BUFFER_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .du_ctl    (du_ctl),
        .top_digit (top_digit)
    );

    ita_digits #(
        .DIGIT_BUFFER_DEPTH(DIGIT_BUFFER_DEPTH)
    ) u_digits (
        .clk       (clk),
        .ctl       (du_ctl),
        .top_digit (top_digit)
    );

endmodule

// ===== rtl/ita_digits.sv =====
// digit register with shared shift unit: load, double dabble step or nibble shift
module ita_digits #(
    parameter int DIGIT_BUFFER_DEPTH = ita_pkg::DIGIT_BUFFER_DEPTH_DEF
) (
    input  logic              clk,
    input  ita_pkg::du_ctl_t  ctl,
    output logic [3:0]        top_digit
);
    import ita_pkg::*;

    localparam int DW = DIGIT_BUFFER_DEPTH * 4;

    logic [DW-1:0]       digit_reg;
    logic [DW-1:0]       digit_next;
    logic [DW-1:0]       adj;
    logic [DEC_BITS-1:0] bin_reg;
    logic [DEC_BITS-1:0] bin_next;

    // add three to every bcd digit of five or more
    always_comb
    begin
        for (int i = 0; i < DIGIT_BUFFER_DEPTH; i++)
        begin
            if (digit_reg[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = digit_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = digit_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        digit_next = digit_reg;
        bin_next   = bin_reg;
        unique case (ctl.cmd)
            DU_LOAD_HEX:
            begin
                digit_next = DW'(ctl.operand);
            end
            DU_LOAD_DEC:
            begin
                digit_next = '0;
                bin_next   = ctl.operand[DEC_BITS-1:0];
            end
            DU_DABBLE:
            begin
                digit_next = {adj[DW-2:0], bin_reg[DEC_BITS-1]};
                bin_next   = {bin_reg[DEC_BITS-2:0], 1'b0};
            end
            DU_NIB:
            begin
                digit_next = {digit_reg[DW-5:0], 4'b0000};
            end
            default:
            begin
                digit_next = digit_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        bin_reg   <= bin_next;
    end

    assign top_digit = digit_reg[DW-1 -: 4];

endmodule

// ===== rtl/ita_seq.sv =====
// sequencer: request decode, prefix text, conversion steps and output register
module ita_seq #(
    parameter int DIGIT_BUFFER_DEPTH = ita_pkg::DIGIT_BUFFER_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ita_pkg::in_t      in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ita_pkg::out_t     out_data,
    output ita_pkg::du_ctl_t  du_ctl,
    input  logic [3:0]        top_digit
);
    import ita_pkg::*;

    localparam int CW = $clog2(DIGIT_BUFFER_DEPTH + 1);

    state_t                   state_reg;
    state_t                   state_next;
    logic [PREFIX_BITS-1:0]   prefix_reg;
    logic [PREFIX_BITS-1:0]   prefix_next;
    logic [2:0]               plen_reg;
    logic [2:0]               plen_next;
    logic                     has_dig_reg;
    logic                     has_dig_next;
    logic                     is_dec_reg;
    logic                     is_dec_next;
    logic                     upper_reg;
    logic                     upper_next;
    logic [CONV_CNT_BITS-1:0] conv_reg;
    logic [CONV_CNT_BITS-1:0] conv_next;
    logic [CW-1:0]            rem_reg;
    logic [CW-1:0]            rem_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    out_t                     out_reg;
    out_t                     out_next;

    logic                     can_emit;
    logic                     emit;
    out_t                     emit_data;
    logic [DEC_BITS-1:0]      low32;
    logic [DEC_BITS-1:0]      mag;
    logic                     neg;

    assign low32    = in_data.value[DEC_BITS-1:0];
    assign neg      = low32[DEC_BITS-1];
    assign mag      = neg ? (~low32 + DEC_BITS'(1)) : low32;
    assign can_emit = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        prefix_next    = prefix_reg;
        plen_next      = plen_reg;
        has_dig_next   = has_dig_reg;
        is_dec_next    = is_dec_reg;
        upper_next     = upper_reg;
        conv_next      = conv_reg;
        rem_next       = rem_reg;
        du_ctl.cmd     = DU_HOLD;
        du_ctl.operand = in_data.value;
        emit           = 1'b0;
        emit_data      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rem_next     = CW'(DIGIT_BUFFER_DEPTH);
                    conv_next    = CONV_CNT_BITS'(DEC_BITS);
                    prefix_next  = '0;
                    plen_next    = 3'd0;
                    has_dig_next = 1'b1;
                    is_dec_next  = 1'b0;
                    upper_next   = 1'b0;
                    unique case (op_t'(in_data.opcode))
                        OP_CHAR:
                        begin
                            prefix_next  = {in_data.value[7:0], 32'd0};
                            plen_next    = 3'd1;
                            has_dig_next = 1'b0;
                            state_next   = ST_PREFIX;
                        end
                        OP_PERCENT:
                        begin
                            prefix_next  = {CH_PERCENT, 32'd0};
                            plen_next    = 3'd1;
                            has_dig_next = 1'b0;
                            state_next   = ST_PREFIX;
                        end
                        OP_SDEC:
                        begin
                            prefix_next    = {CH_MINUS, 32'd0};
                            plen_next      = neg ? 3'd1 : 3'd0;
                            is_dec_next    = 1'b1;
                            du_ctl.cmd     = DU_LOAD_DEC;
                            du_ctl.operand = {{(PTR_BITS-DEC_BITS){1'b0}}, mag};
                            state_next     = neg ? ST_PREFIX : ST_CONVERT;
                        end
                        OP_UDEC:
                        begin
                            is_dec_next    = 1'b1;
                            du_ctl.cmd     = DU_LOAD_DEC;
                            du_ctl.operand = {{(PTR_BITS-DEC_BITS){1'b0}}, low32};
                            state_next     = ST_CONVERT;
                        end
                        OP_PTR:
                        begin
                            if (in_data.value == '0)
                            begin
                                prefix_next  = NIL_TEXT;
                                plen_next    = 3'd5;
                                has_dig_next = 1'b0;
                            end
                            else
                            begin
                                prefix_next = {CH_ZERO, CH_X, 24'd0};
                                plen_next   = 3'd2;
                                du_ctl.cmd  = DU_LOAD_HEX;
                            end
                            state_next = ST_PREFIX;
                        end
                        OP_HEXLO,
                        OP_HEXUP:
                        begin
                            upper_next     = (op_t'(in_data.opcode) == OP_HEXUP);
                            du_ctl.cmd     = DU_LOAD_HEX;
                            du_ctl.operand = {{(PTR_BITS-DEC_BITS){1'b0}}, low32};
                            state_next     = ST_SKIP;
                        end
                        OP_NONE:
                        begin
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PREFIX:
            begin
                if (can_emit)
                begin
                    emit                 = 1'b1;
                    emit_data.ascii_char = prefix_reg[PREFIX_BITS-1 -: 8];
                    emit_data.last_char  = (plen_reg == 3'd1) && !has_dig_reg;
                    prefix_next          = {prefix_reg[PREFIX_BITS-9:0], 8'd0};
                    plen_next            = plen_reg - 3'd1;
                    if (plen_reg == 3'd1)
                    begin
                        if (!has_dig_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (is_dec_reg)
                        begin
                            state_next = ST_CONVERT;
                        end
                        else
                        begin
                            state_next = ST_SKIP;
                        end
                    end
                end
            end
            ST_CONVERT:
            begin
                du_ctl.cmd = DU_DABBLE;
                conv_next  = conv_reg - CONV_CNT_BITS'(1);
                if (conv_reg == CONV_CNT_BITS'(1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_digit == 4'd0 && rem_reg > CW'(1))
                begin
                    du_ctl.cmd = DU_NIB;
                    rem_next   = rem_reg - CW'(1);
                end
                else
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (can_emit)
                begin
                    emit                 = 1'b1;
                    emit_data.ascii_char = digit_char(top_digit, upper_reg);
                    emit_data.last_char  = (rem_reg == CW'(1));
                    du_ctl.cmd           = DU_NIB;
                    rem_next             = rem_reg - CW'(1);
                    if (rem_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_data;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prefix_reg  <= prefix_next;
        plen_reg    <= plen_next;
        has_dig_reg <= has_dig_next;
        is_dec_reg  <= is_dec_next;
        upper_reg   <= upper_next;
        conv_reg    <= conv_next;
        rem_reg     <= rem_next;
        out_reg     <= out_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/ita_checker.sv =====
// port level checks for the integer to ascii formatter, bound to the top level
module ita_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input ita_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_stall,
    input ita_pkg::out_t out_data
);
    import ita_pkg::*;

    // a held character must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output character changed while stalled");

    // a request that prints something keeps the block busy
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.opcode != OP_NONE |=> in_stall)
        else $error("request taken without going busy");

    // more characters pending means no new request
    a_busy_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_char |-> in_stall)
        else $error("new request possible before last character");

    // percent prints a single final character from the prefix state when the output was empty at the request
    a_percent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.opcode == OP_PERCENT && !out_valid
        |=> ##1 out_valid && out_data.ascii_char == CH_PERCENT && out_data.last_char)
        else $error("percent conversion output wrong");

endmodule

bind integer_to_ascii_formatter_top ita_checker u_ita_checker (.*);

// ===== tb/tb_integer_to_ascii_formatter_top.sv =====
// testbench for integer_to_ascii_formatter_top: directed and random conversions, predicted text checked per character
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter_top;

    import ita_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_WAIT  = 100;
    localparam int RANDOM_ITEMS = 115;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    in_t pending_reqs[$];
    out_t expected_chars[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    integer_to_ascii_formatter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // text that one conversion request is expected to print
    function automatic void predict_text(in_t req);
        logic [7:0] text[$];
        logic [3:0] digits[$];
        logic [63:0] mag;
        logic [4:0] base;
        logic [7:0] ch;
        logic numeric;
        logic upper;
        out_t item;
        mag = '0;
        base = 5'd10;
        numeric = 1'b0;
        upper = 1'b0;
        case (op_t'(req.opcode))
            OP_CHAR:
            begin
                text.push_back(req.value[7:0]);
            end
            OP_SDEC:
            begin
                numeric = 1'b1;
                if (req.value[31])
                begin
                    text.push_back(CH_MINUS);
                    mag = 64'h1_0000_0000 - {32'd0, req.value[31:0]};
                end
                else
                begin
                    mag = {32'd0, req.value[31:0]};
                end
            end
            OP_UDEC:
            begin
                numeric = 1'b1;
                mag = {32'd0, req.value[31:0]};
            end
            OP_PTR:
            begin
                if (req.value == '0)
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        text.push_back(NIL_TEXT[39 - 8 * i -: 8]);
                    end
                end
                else
                begin
                    text.push_back(CH_ZERO);
                    text.push_back(CH_X);
                    numeric = 1'b1;
                    base = 5'd16;
                    mag = req.value;
                end
            end
            OP_HEXLO, OP_HEXUP:
            begin
                numeric = 1'b1;
                base = 5'd16;
                upper = (op_t'(req.opcode) == OP_HEXUP);
                mag = {32'd0, req.value[31:0]};
            end
            OP_PERCENT:
            begin
                text.push_back(CH_PERCENT);
            end
            default:
            begin
            end
        endcase
        if (numeric)
        begin
            do
            begin
                digits.push_front(4'(mag % base));
                mag = mag / base;
            end
            while (mag != '0);
            foreach (digits[i])
            begin
                if (digits[i] < 4'd10)
                begin
                    ch = CH_ZERO + {4'd0, digits[i]};
                end
                else
                begin
                    ch = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, digits[i]} - 8'd10;
                end
                text.push_back(ch);
            end
        end
        foreach (text[i])
        begin
            item.ascii_char = text[i];
            item.last_char = (i == text.size() - 1);
            expected_chars.push_back(item);
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_text(in_data);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_reqs.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // character monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("out_data: no character expected, actual %h", out_data);
                    mismatch_count++;
                end
                else
                begin
                    if (out_data.ascii_char !== expected_chars[0].ascii_char)
                    begin
                        $error("ascii_char: expected %h, actual %h",
                               expected_chars[0].ascii_char, out_data.ascii_char);
                        mismatch_count++;
                    end
                    if (out_data.last_char !== expected_chars[0].last_char)
                    begin
                        $error("last_char: expected %b, actual %b",
                               expected_chars[0].last_char, out_data.last_char);
                        mismatch_count++;
                    end
                    void'(expected_chars.pop_front());
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_request(input op_t op, input logic [63:0] value);
        in_t req;
        req.opcode = op;
        req.value = value;
        pending_reqs.push_back(req);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = v >> $urandom_range(0, 63);
            1: v = {$urandom, 32'h8000_0000 | $urandom};
            2: v = {$urandom, 32'd0} | $urandom_range(0, 20);
            default: ;
        endcase
        return v;
    endfunction

    // sender holds off until every character has come back
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_chars.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    initial
    begin
        int idle_modes[4][2];
        idle_modes = '{'{0, 0}, '{76, 0}, '{0, 76}, '{22, 22}};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_request(OP_CHAR, 64'h0);
        add_request(OP_CHAR, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(OP_CHAR, 64'h1234_5678_9ABC_DE41);
        add_request(OP_SDEC, 64'h0);
        add_request(OP_SDEC, 64'h7FFF_FFFF);
        add_request(OP_SDEC, 64'h8000_0000);
        add_request(OP_SDEC, 64'hFFFF_FFFF);
        add_request(OP_SDEC, 64'hFFFF_FFFF_0000_0001);
        add_request(OP_UDEC, 64'h0);
        add_request(OP_UDEC, 64'hFFFF_FFFF);
        add_request(OP_UDEC, 64'hABCD_0000_0000_000A);
        add_request(OP_PTR, 64'h0);
        add_request(OP_PTR, 64'h1);
        add_request(OP_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(OP_PTR, 64'h8000_0000_0000_0000);
        add_request(OP_PTR, 64'h0000_0001_0000_0000);
        add_request(OP_HEXLO, 64'h0);
        add_request(OP_HEXLO, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(OP_HEXUP, 64'hDEAD_BEEF);
        add_request(OP_HEXUP, 64'hFFFF_FFFF_0000_0000);
        add_request(OP_PERCENT, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(OP_NONE, 64'h5555_5555_5555_5555);
        add_request(OP_NONE, 64'h0);
        add_request(OP_HEXLO, 64'hA);
        wait_drained();

        foreach (idle_modes[m])
        begin
            send_idle_pct = idle_modes[m][0];
            recv_stall_pct = idle_modes[m][1];
            for (int i = 0; i < RANDOM_ITEMS; i++)
            begin
                add_request(op_t'($urandom_range(0, 7)), random_value());
            end
            wait_drained();
        end

        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== integer_to_ascii_formatter_top.f =====
rtl/ita_pkg.sv
rtl/ita_digits.sv
rtl/ita_seq.sv
rtl/integer_to_ascii_formatter_top.sv
rtl/ita_checker.sv
tb/tb_integer_to_ascii_formatter_top.sv
